FILE: rtl/fpd_pkg.sv
// shared types and codes for the filament presence detector
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

    // filtered sensor status codes
    typedef enum logic [2:0] {
        ST_UNINIT        = 3'd0,
        ST_FILAMENT      = 3'd1,
        ST_NO_FILAMENT   = 3'd2,
        ST_NOT_CONNECTED = 3'd3,
        ST_DISABLED      = 3'd4
    } sense_state_t;

    // change request policy codes
    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_LEVEL = 2'd1;
    localparam logic [1:0] MODE_NEVER = 2'd2;

    // register indexes, taken from paddr[2]
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic       enable;
        logic [1:0] mode;
        logic       reinit;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/filament_presence_detector.sv
// filament presence detector: two-phase pin check, verdict filter, change request
// an accepted item's result is registered into the result register, or into the skid entry while that is held
// throughput: one item per cycle while in_stall is low, state update is a single pass of small logic
// a two-entry output stage (result register plus skid) keeps input flowing
// while a result waits; in_stall rises only when both entries are full
// reset: async active low, status uninitialized, pull-up phase, mode edge
`timescale 1ns / 1ps
`default_nettype none

module filament_presence_detector
    import fpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              pin_level,
    input  wire logic              printing_active,
    input  wire logic              user_wait,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   pull_select,
    output logic      [2:0]        sensor_status,
    output logic                   runout,
    output logic                   change_request
);

    typedef struct packed {
        logic         pull;
        sense_state_t status;
        logic         runout;
        logic         fire;
    } result_t;

    cfg_t         cfg;
    sense_state_t status_reg;
    sense_state_t status_next;
    sense_state_t prev_reg;
    sense_state_t prev_next;
    logic         phase_reg;
    logic         phase_next;
    logic         req_reg;
    logic         req_next;
    result_t      res;
    result_t      out_reg;
    result_t      skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         accept;
    logic         out_take;
    logic         filament_before;
    logic         want;
    logic         fire;
    sense_state_t verdict;

    fpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid & ~skid_valid_reg;
    assign out_take = out_valid_reg & ~out_stall;

    // one tick of detection
    always_comb
    begin
        status_next     = status_reg;
        prev_next       = prev_reg;
        phase_next      = phase_reg;
        req_next        = req_reg;
        fire            = 1'b0;
        filament_before = (status_reg == ST_FILAMENT);
        want            = (cfg.mode == MODE_LEVEL) ||
                          ((cfg.mode == MODE_EDGE) && filament_before);
        verdict         = pin_level ? ST_FILAMENT : ST_NOT_CONNECTED;
        if (status_reg != ST_DISABLED)
        begin
            if (!phase_reg)
            begin
                if (pin_level)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    if (prev_reg == ST_NO_FILAMENT)
                        status_next = ST_NO_FILAMENT;
                    prev_next = ST_NO_FILAMENT;
                    fire = ~req_reg && (status_next == ST_NO_FILAMENT) && want &&
                           printing_active && ~user_wait;
                    if (fire)
                        req_next = 1'b1;
                end
            end
            else
            begin
                if (prev_reg == verdict)
                    status_next = verdict;
                prev_next  = verdict;
                phase_next = 1'b0;
            end
            // a pause re-arms the request
            if (user_wait)
                req_next = 1'b0;
        end
    end

    assign res.pull   = phase_next;
    assign res.status = status_next;
    assign res.runout = (status_next == ST_NO_FILAMENT);
    assign res.fire   = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_UNINIT;
            prev_reg   <= ST_UNINIT;
            phase_reg  <= 1'b0;
            req_reg    <= 1'b0;
        end
        else if (cfg.reinit)
        begin
            status_reg <= cfg.enable ? ST_UNINIT : ST_DISABLED;
            prev_reg   <= cfg.enable ? ST_UNINIT : ST_DISABLED;
            phase_reg  <= 1'b0;
        end
        else if (accept)
        begin
            status_reg <= status_next;
            prev_reg   <= prev_next;
            phase_reg  <= phase_next;
            req_reg    <= req_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_reg  <= skid_valid_reg | accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (accept)
            skid_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign pull_select    = out_reg.pull;
    assign sensor_status  = out_reg.status;
    assign runout         = out_reg.runout;
    assign change_request = out_reg.fire;

`ifndef SYNTHESIS
    a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while result register empty");

    a_fire_is_runout : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && change_request |-> runout && !pull_select)
        else $error("change request without runout in pull-up phase");

    a_disabled_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sensor_status == ST_DISABLED) |-> !pull_select && !change_request)
        else $error("disabled status with activity on the result");

    a_fire_sets_sent : assert property (@(posedge clk) disable iff (!rst_n)
        accept && fire && !cfg.reinit |=> req_reg)
        else $error("request fired but request_sent not set");
`endif

endmodule

`default_nettype wire

FILE: rtl/fpd_cfg.sv
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module fpd_cfg
    import fpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic       enable_reg;
    logic       enable_next;
    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       reinit_next;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    always_comb
    begin
        enable_next = enable_reg;
        mode_next   = mode_reg;
        reinit_next = 1'b0;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLE:
                begin
                    enable_next = pwdata[0];
                    reinit_next = 1'b1;
                end
                REG_MODE:   mode_next = pwdata[1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            mode_reg   <= MODE_EDGE;
        end
        else
        begin
            enable_reg <= enable_next;
            mode_reg   <= mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_ENABLE: prdata[0]   = enable_reg;
            REG_MODE:   prdata[1:0] = mode_reg;
            default:    ;
        endcase
    end

    // reinit is combinational so the state update lands on the write edge
    assign cfg.enable = enable_next;
    assign cfg.mode   = mode_reg;
    assign cfg.reinit = reinit_next;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the filament presence detector
`timescale 1ns / 1ps

module tb_top
    import fpd_pkg::*;
();

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;

    typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

    typedef struct {
        logic pin;
        logic printing;
        logic paused;
    } tick_t;

    typedef struct {
        logic         pull;
        sense_state_t status;
        logic         runout;
        logic         change;
    } reading_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              pin_level = 1'b0;
    logic              printing_active = 1'b0;
    logic              user_wait = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              pull_select;
    logic [2:0]        sensor_status;
    logic              runout;
    logic              change_request;

    filament_presence_detector dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pin_level       (pin_level),
        .printing_active (printing_active),
        .user_wait       (user_wait),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pull_select     (pull_select),
        .sensor_status   (sensor_status),
        .runout          (runout),
        .change_request  (change_request)
    );

    always #5 clk = ~clk;

    tick_t    pending_ticks[$];
    reading_t expected_readings[$];
    pace_t    pace = PACE_SLOW_SINK;
    int       errors = 0;
    int       readings_seen = 0;
    logic     in_taken = 1'b0;

    // detector mirror: configuration and sensing state
    logic         cfg_enable;
    logic [1:0]   cfg_mode;
    sense_state_t filt_status;
    sense_state_t last_verdict;
    logic         pull_down_phase;
    logic         request_sent;

    function automatic void filter_verdict(input sense_state_t v);
        if (last_verdict == v)
            filt_status = v;
        last_verdict = v;
    endfunction

    task automatic detect_tick(input tick_t t);
        reading_t r;
        logic     was_filament;
        logic     wants;
        logic     fire;
        fire = 1'b0;
        if (filt_status != ST_DISABLED)
        begin
            if (!pull_down_phase)
            begin
                if (t.pin)
                    pull_down_phase = 1'b1;
                else
                begin
                    was_filament = (filt_status == ST_FILAMENT);
                    filter_verdict(ST_NO_FILAMENT);
                    wants = (cfg_mode == MODE_LEVEL) || (cfg_mode == MODE_EDGE && was_filament);
                    if (!request_sent && filt_status == ST_NO_FILAMENT && wants &&
                        t.printing && !t.paused)
                    begin
                        fire = 1'b1;
                        request_sent = 1'b1;
                    end
                end
            end
            else
            begin
                filter_verdict(t.pin ? ST_FILAMENT : ST_NOT_CONNECTED);
                pull_down_phase = 1'b0;
            end
            if (t.paused)
                request_sent = 1'b0;
        end
        r.pull = pull_down_phase;
        r.status = filt_status;
        r.runout = (filt_status == ST_NO_FILAMENT);
        r.change = fire;
        expected_readings.push_back(r);
    endtask

    function automatic logic roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // driver: new item at the falling edge once the previous one was taken
    always @(negedge clk)
    begin
        tick_t t;
        int    gap_pct;
        gap_pct = (pace == PACE_SLOW_SINK) ? 27 : (pace == PACE_SLOW_SOURCE) ? 62 : 0;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_ticks.size() > 0 && !roll(gap_pct))
            begin
                t = pending_ticks.pop_front();
                in_valid <= 1'b1;
                pin_level <= t.pin;
                printing_active <= t.printing;
                user_wait <= t.paused;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall plus a long hold-off now and then
    int hold_left = 0;
    int next_hold_at = 300;

    always @(negedge clk)
    begin
        int stall_pct;
        stall_pct = (pace == PACE_SLOW_SINK) ? 62 : (pace == PACE_SLOW_SOURCE) ? 27 : 0;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (readings_seen >= next_hold_at)
        begin
            hold_left = HOLD_CYCLES;
            next_hold_at = next_hold_at + 1100;
            out_stall <= 1'b1;
        end
        else
            out_stall <= roll(stall_pct);
    end

    // input acceptance feeds the mirror, output acceptance is checked
    always @(posedge clk)
    begin
        tick_t    t;
        reading_t exp_r;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            t.pin = pin_level;
            t.printing = printing_active;
            t.paused = user_wait;
            detect_tick(t);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            readings_seen = readings_seen + 1;
            if (expected_readings.size() == 0)
            begin
                $error("unexpected item: status %0d", sensor_status);
                errors = errors + 1;
            end
            else
            begin
                exp_r = expected_readings.pop_front();
                if (pull_select !== exp_r.pull)
                begin
                    $error("pull_select: expected %0d, got %0d", exp_r.pull, pull_select);
                    errors = errors + 1;
                end
                if (sensor_status !== exp_r.status)
                begin
                    $error("sensor_status: expected %0d, got %0d", exp_r.status, sensor_status);
                    errors = errors + 1;
                end
                if (runout !== exp_r.runout)
                begin
                    $error("runout: expected %0d, got %0d", exp_r.runout, runout);
                    errors = errors + 1;
                end
                if (change_request !== exp_r.change)
                begin
                    $error("change_request: expected %0d, got %0d", exp_r.change, change_request);
                    errors = errors + 1;
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    task automatic queue_tick(input logic pin, input logic printing, input logic paused);
        tick_t t;
        t.pin = pin;
        t.printing = printing;
        t.paused = paused;
        pending_ticks.push_back(t);
    endtask

    // wait until every queued item is through and its reading checked
    task automatic settle();
        while (pending_ticks.size() > 0 || in_valid || expected_readings.size() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_ENABLE)
        begin
            cfg_enable = value[0];
            filt_status = value[0] ? ST_UNINIT : ST_DISABLED;
            last_verdict = filt_status;
            pull_down_phase = 1'b0;
        end
        else
            cfg_mode = value[1:0];
        // read back
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        want = (idx == REG_ENABLE) ? DATA_W'(cfg_enable) : DATA_W'(cfg_mode);
        if (got !== want)
        begin
            $error("register %0d: expected %0d, got %0d", idx, want, got);
            errors = errors + 1;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // sensor scenarios: filament present, run out, unplugged, or noise
    task automatic queue_scenarios(input int count);
        int   kind;
        int   len;
        int   j;
        logic pin;
        while (count > 0)
        begin
            kind = $urandom_range(3);
            len = $urandom_range(24, 2);
            for (j = 0; j < len && count > 0; j++)
            begin
                case (kind)
                    0: pin = 1'b1;
                    1: pin = 1'b0;
                    2: pin = (j % 2 == 0);
                    default: pin = 1'($urandom_range(1));
                endcase
                if (roll(6))
                    pin = ~pin;
                queue_tick(pin, roll(80), roll(12));
                count = count - 1;
            end
        end
    endtask

    int         chunk_len[6]  = '{300, 300, 280, 280, 40, 450};
    logic       chunk_en[6]   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [1:0] chunk_mode[6] = '{MODE_EDGE, MODE_LEVEL, MODE_NEVER, MODE_UNUSED,
                                  MODE_LEVEL, MODE_EDGE};

    initial
    begin
        cfg_enable = 1'b1;
        cfg_mode = MODE_EDGE;
        filt_status = ST_UNINIT;
        last_verdict = ST_UNINIT;
        pull_down_phase = 1'b0;
        request_sent = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: edge mode, filament found, then runout while printing
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b1);
        // unplugged sensor, then filament back, then runout while not printing
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0);
        settle();

        // level mode fires without a prior filament state
        write_reg(REG_MODE, DATA_W'(MODE_LEVEL));
        write_reg(REG_ENABLE, DATA_W'(1));
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        settle();
        // pause while disabled must not re-arm the request
        write_reg(REG_ENABLE, DATA_W'(0));
        queue_tick(1'b0, 1'b1, 1'b1);
        queue_tick(1'b1, 1'b0, 1'b0);
        settle();
        write_reg(REG_ENABLE, DATA_W'(1));
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b1);
        queue_tick(1'b0, 1'b1, 1'b0);
        settle();
        // undefined mode acts as never
        write_reg(REG_MODE, DATA_W'(MODE_UNUSED));
        queue_tick(1'b0, 1'b1, 1'b1);
        queue_tick(1'b0, 1'b1, 1'b0);
        settle();

        for (int k = 0; k < 6; k++)
        begin
            pace = (k < 2) ? PACE_SLOW_SINK : (k < 4) ? PACE_SLOW_SOURCE : PACE_FULL;
            write_reg(REG_MODE, DATA_W'(chunk_mode[k]));
            write_reg(REG_ENABLE, DATA_W'(chunk_en[k]));
            queue_scenarios(chunk_len[k]);
            settle();
        end

        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fpd_pkg.sv
rtl/fpd_cfg.sv
rtl/filament_presence_detector.sv
verif/tb_top.sv
